// ===== sv/ueds_pkg.sv =====
// ---------------------------------------------------------------------------
// ueds_pkg
// Shared types and constants of the undirected weighted edge store.
// ---------------------------------------------------------------------------
package ueds_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 32;

  localparam int ACTION_BITS = 2;
  localparam int VERTEX_BITS = 6;
  localparam int VC_BITS     = 7;
  localparam int COUNT_BITS  = 13;
  localparam int VC_RESET    = 64;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_ADD        = 2'd0,
    ACT_REMOVE     = 2'd1,
    ACT_QUERY      = 2'd2,
    ACT_COMPLEMENT = 2'd3
  } action_t;

endpackage

// ===== sv/undirected_weighted_edge_store_top.sv =====
// ---------------------------------------------------------------------------
// undirected_weighted_edge_store_top
// Undirected weighted graph held as a lower-triangular adjacency store.
// ---------------------------------------------------------------------------
// Usage:
//   s_* stream carries one command beat: action, vertex_a, vertex_b, weight_in.
//   m_* stream returns exactly one result beat per command: out_of_range,
//   edge_present, weight_out, edge_count.
//   cfg_wr_en/cfg_wr_data load vertex_count; write it only while idle.
// Operation:
//   Add, remove and query are one read-modify-write of the entry RAM: the
//   command is taken, the entry is read (registered RAM read) and, for an
//   in-range add or remove, written back as the result is registered; this
//   waits while the output slot is full. The next command is read only after
//   the previous result is registered, so no two accesses to one entry overlap.
//   Complement sweeps entries 0 .. n(n+1)/2-1 of the RAM one per cycle,
//   flipping each off-diagonal present bit.
// Reset:
//   rst starts a clearing pass that writes zero to all
//   MAX_VERTICES*(MAX_VERTICES+1)/2 entries, one per cycle; s_tready stays
//   low until it is done. Count clears, vertex_count returns to 64.
// Stall:
//   A result waits in the output register while m_tready is low; one more
//   command is taken meanwhile and its result holds inside until the slot frees.
// ---------------------------------------------------------------------------
module undirected_weighted_edge_store_top #(
  parameter int MAX_VERTICES = ueds_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = ueds_pkg::WEIGHT_BITS_DEF,
  localparam int IN_BITS  = ((2 * ueds_pkg::VERTEX_BITS + ueds_pkg::ACTION_BITS
                              + WEIGHT_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = ((2 + WEIGHT_BITS + ueds_pkg::COUNT_BITS + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [ueds_pkg::VC_BITS-1:0] cfg_wr_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // action, vertex_a, vertex_b, weight_in (from bit 0 up)
  input  logic [IN_BITS-1:0]           s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // out_of_range, edge_present, weight_out, edge_count (from bit 0 up)
  output logic [OUT_BITS-1:0]          m_tdata
);

  localparam int VB    = ueds_pkg::VERTEX_BITS;
  localparam int CB    = ueds_pkg::COUNT_BITS;
  localparam int NB    = ueds_pkg::VC_BITS;
  localparam int AB    = ueds_pkg::ACTION_BITS;
  localparam int DEPTH = MAX_VERTICES * (MAX_VERTICES + 1) / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int WORD  = WEIGHT_BITS + 1;
  localparam int IDXB  = 2 * VB + 1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RMW, ST_SWEEP, ST_SWEEP_END
  } state_t;

  state_t                 state;
  logic [AW-1:0]          clr_addr;
  logic [NB-1:0]          vertex_count;
  logic [CB-1:0]          edge_count;

  ueds_pkg::action_t      act_q;
  logic                   oor_q;
  logic [AW-1:0]          idx_q;
  logic [WEIGHT_BITS-1:0] w_q;

  logic [AW-1:0]          sw_addr;
  logic [NB-1:0]          sw_row;
  logic [NB-1:0]          sw_col;
  logic                   sw_pend;
  logic [AW-1:0]          sw_pend_addr;
  logic                   sw_pend_diag;

  logic                   out_oor;
  logic                   out_present;
  logic [WEIGHT_BITS-1:0] out_weight;
  logic [CB-1:0]          out_count;

  // input beat fields
  ueds_pkg::action_t      in_action;
  logic [VB-1:0]          in_a;
  logic [VB-1:0]          in_b;
  logic [WEIGHT_BITS-1:0] in_w;

  logic [NB-1:0]          live_n;
  logic [NB-1:0]          live_nm1;
  logic [2*NB-1:0]        pair_prod;
  logic [CB-1:0]          pair_count;
  logic [VB-1:0]          in_hi;
  logic [VB-1:0]          in_lo;
  logic [IDXB-1:0]        in_idx_full;
  logic [AW-1:0]          in_idx;
  logic                   in_oor;
  logic                   accept;
  logic                   out_free;
  logic                   out_load;

  logic                   ram_wr_en;
  logic [AW-1:0]          ram_wr_addr;
  logic [WORD-1:0]        ram_wr_data;
  logic                   ram_rd_en;
  logic [AW-1:0]          ram_rd_addr;
  logic [WORD-1:0]        ram_rd_data;

  logic                   old_present;
  logic                   rmw_present;
  logic [WEIGHT_BITS-1:0] rmw_weight;
  logic [CB-1:0]          rmw_count;

  assign in_action = ueds_pkg::action_t'(s_tdata[AB-1:0]);
  assign in_a      = s_tdata[AB+VB-1:AB];
  assign in_b      = s_tdata[AB+2*VB-1:AB+VB];
  assign in_w      = s_tdata[AB+2*VB+WEIGHT_BITS-1:AB+2*VB];

  assign live_n     = (int'(vertex_count) > MAX_VERTICES) ? NB'(MAX_VERTICES)
                                                          : vertex_count;
  assign live_nm1   = (live_n == '0) ? '0 : live_n - NB'(1);
  assign pair_prod  = live_n * live_nm1;
  assign pair_count = CB'(pair_prod >> 1);

  assign in_hi       = (in_a > in_b) ? in_a : in_b;
  assign in_lo       = (in_a > in_b) ? in_b : in_a;
  assign in_idx_full = IDXB'((IDXB'(in_hi) * IDXB'({1'b0, in_hi} + 1'b1)) >> 1)
                       + IDXB'(in_lo);
  assign in_idx      = AW'(in_idx_full);
  assign in_oor      = ({1'b0, in_a} >= live_n) || ({1'b0, in_b} >= live_n);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free &&
                    ((state == ST_RMW) || (state == ST_SWEEP_END && !sw_pend));

  assign old_present = ram_rd_data[WEIGHT_BITS];

  always_comb begin
    rmw_present = old_present;
    rmw_weight  = ram_rd_data[WEIGHT_BITS-1:0];
    rmw_count   = edge_count;
    case (act_q)
      ueds_pkg::ACT_ADD: begin
        rmw_present = 1'b1;
        rmw_weight  = w_q;
        if (!old_present) rmw_count = edge_count + CB'(1);
      end
      ueds_pkg::ACT_REMOVE: begin
        rmw_present = 1'b0;
        rmw_weight  = '0;
        if (old_present) rmw_count = edge_count - CB'(1);
      end
      default: ;
    endcase
    if (oor_q) begin
      rmw_present = 1'b0;
      rmw_weight  = '0;
      rmw_count   = edge_count;
    end
  end

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = sw_pend_addr;
    ram_wr_data = {~ram_rd_data[WEIGHT_BITS], ram_rd_data[WEIGHT_BITS-1:0]};
    case (state)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
        ram_wr_data = '0;
      end
      ST_RMW: begin
        ram_wr_en   = out_free && !oor_q &&
                      (act_q == ueds_pkg::ACT_ADD || act_q == ueds_pkg::ACT_REMOVE);
        ram_wr_addr = idx_q;
        ram_wr_data = {rmw_present, rmw_weight};
      end
      ST_SWEEP, ST_SWEEP_END: begin
        // diagonal entries keep their present bit
        ram_wr_en = sw_pend && !sw_pend_diag;
      end
      default: ;
    endcase
  end

  assign ram_rd_en   = accept || (state == ST_SWEEP);
  assign ram_rd_addr = (state == ST_SWEEP) ? sw_addr : in_idx;

  ueds_ram #(
    .WIDTH (WORD),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      vertex_count <= NB'(ueds_pkg::VC_RESET);
      edge_count   <= '0;
      m_tvalid     <= 1'b0;
      sw_pend      <= 1'b0;
    end else begin
      if (cfg_wr_en) vertex_count <= cfg_wr_data;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            act_q <= in_action;
            oor_q <= in_oor;
            idx_q <= in_idx;
            w_q   <= in_w;
            if (in_action == ueds_pkg::ACT_COMPLEMENT) begin
              sw_addr <= '0;
              sw_row  <= '0;
              sw_col  <= '0;
              sw_pend <= 1'b0;
              state   <= (live_n == '0) ? ST_SWEEP_END : ST_SWEEP;
            end else begin
              state <= ST_RMW;
            end
          end
        end
        ST_RMW: begin
          // hold the read word until the output slot frees
          if (out_free) begin
            edge_count  <= rmw_count;
            out_oor     <= oor_q;
            out_present <= rmw_present;
            out_weight  <= rmw_weight;
            out_count   <= rmw_count;
            state       <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          sw_pend      <= 1'b1;
          sw_pend_addr <= sw_addr;
          sw_pend_diag <= (sw_col == sw_row);
          sw_addr      <= sw_addr + AW'(1);
          if (sw_col == sw_row) begin
            if (sw_row == live_nm1) begin
              state <= ST_SWEEP_END;
            end else begin
              sw_row <= sw_row + NB'(1);
              sw_col <= '0;
            end
          end else begin
            sw_col <= sw_col + NB'(1);
          end
        end
        ST_SWEEP_END: begin
          // drain the last write-back before reporting
          if (sw_pend) begin
            sw_pend <= 1'b0;
          end else if (out_free) begin
            edge_count  <= pair_count - edge_count;
            out_oor     <= 1'b0;
            out_present <= 1'b0;
            out_weight  <= '0;
            out_count   <= pair_count - edge_count;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = OUT_BITS'({out_count, out_weight, out_present, out_oor});

  // commands are never accepted back to back
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command accepted in consecutive cycles");

  // an out-of-range result never reports a present edge
  a_oor_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_oor && out_present))
    else $error("out-of-range result marks edge present");

  // the store is not written while waiting for a command
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !ram_wr_en)
    else $error("RAM write while idle");

endmodule

// ===== sv/ueds_ram.sv =====
// ---------------------------------------------------------------------------
// ueds_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module ueds_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2080
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold the last read word while no read is issued
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
